/* sv/tdr_pkg.sv */
// Shared types and constants for the text display refresh buffer.
// No dependencies; every other file imports this package.
package tdr_pkg;

  // Default geometry
  localparam int DEF_DISPLAYS = 2;
  localparam int DEF_ROWS     = 2;
  localparam int DEF_COLS     = 16;

  // Fill character after reset, clear and init
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Command codes
  typedef enum logic [2:0] {
    ACT_PUT   = 3'd0,
    ACT_BEGIN = 3'd1,
    ACT_CONT  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_INIT  = 3'd4,
    ACT_TICK  = 3'd5
  } tdr_action_e;

  // Command transaction
  typedef struct packed {
    logic [2:0] action;
    logic       display_id;
    logic [7:0] char_code;
    logic       row;
    logic [3:0] column;
  } tdr_in_t;

  // Refresh cell transaction
  typedef struct packed {
    logic       out_display;
    logic       out_row;
    logic [3:0] out_column;
    logic [7:0] out_char;
  } tdr_out_t;

  // Memory request flags from the controller to the store
  typedef struct packed {
    logic wr;
    logic rd;
    logic clr;
  } tdr_mem_cmd_t;

endpackage

/* sv/text_display_refresh_buffer.sv */
// Top level of the text display refresh buffer: command channel, refresh
// cell channel, read stage and output register. Uses tdr_pkg, tdr_ctrl, tdr_store.
//
// Usage:
//   cmd channel  (cmd_valid/cmd_ready, cmd): put char, string begin,
//     string continue, clear, init and refresh tick transactions.
//   cell channel (cell_valid/cell_ready, cell_data): one transaction per
//     refresh tick of an existing display, giving display, row, column
//     and the stored character.
//   Clear and init need no fill pass; one command
//   is accepted per cycle while the cell channel drains.
//   A tick's RAM read is registered in the read stage; its cell then moves
//   into the output register once that register is free or being taken.
//   Reset empties the pipeline, rewinds all cursors and drops every cell
//   valid bit at once, so the store reads as spaces without a fill pass.
//   When the receiver stalls, the output register holds its cell and one
//   more tick result waits in the read stage; cmd_ready then drops until
//   the output register is taken.
module text_display_refresh_buffer #(
  parameter int DISPLAYS = tdr_pkg::DEF_DISPLAYS,
  parameter int ROWS     = tdr_pkg::DEF_ROWS,
  parameter int COLS     = tdr_pkg::DEF_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tdr_pkg::tdr_in_t  cmd,
  output logic              cell_valid,
  input  logic              cell_ready,
  output tdr_pkg::tdr_out_t cell_data
);
  import tdr_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int DEPTH = DISPLAYS * CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;

  tdr_mem_cmd_t  mcmd;
  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic [DW-1:0] clr_disp;
  tdr_out_t      meta;
  logic [7:0]    rchar;
  logic          fire, load;
  logic          p_valid;
  tdr_out_t      p_meta;

  // Handshake: stop only when both result slots are full
  assign cmd_ready = !(p_valid && cell_valid && !cell_ready);
  assign fire      = cmd_valid && cmd_ready;
  assign load      = p_valid && (!cell_valid || cell_ready);

  tdr_ctrl #(
    .DISPLAYS(DISPLAYS),
    .ROWS    (ROWS),
    .COLS    (COLS),
    .AW      (AW),
    .DW      (DW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .cmd     (cmd),
    .mcmd    (mcmd),
    .addr    (addr),
    .wdata   (wdata),
    .clr_disp(clr_disp),
    .meta    (meta)
  );

  tdr_store #(
    .DEPTH   (DEPTH),
    .AW      (AW),
    .CELLS   (CELLS),
    .DW      (DW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .mcmd    (mcmd),
    .addr    (addr),
    .wdata   (wdata),
    .clr_disp(clr_disp),
    .rchar   (rchar)
  );

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (mcmd.rd) begin
      p_valid <= 1'b1;
    end else if (load) begin
      p_valid <= 1'b0;
    end
  end

  // Read stage tag
  always_ff @(posedge clk) begin
    if (mcmd.rd) begin
      p_meta <= meta;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (load) begin
      cell_valid <= 1'b1;
    end else if (cell_ready) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cell_data.out_display <= p_meta.out_display;
      cell_data.out_row     <= p_meta.out_row;
      cell_data.out_column  <= p_meta.out_column;
      cell_data.out_char    <= rchar;
    end
  end

endmodule

/* sv/tdr_store.sv */
// Character store: one synchronous RAM plus a valid bit per cell.
// An invalid cell reads as a space, so clear needs no fill pass. Uses tdr_pkg.
module tdr_store #(
  parameter int DEPTH    = 64,
  parameter int AW       = 6,
  parameter int CELLS    = 32,
  parameter int DW       = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tdr_pkg::tdr_mem_cmd_t mcmd,
  input  logic [AW-1:0]        addr,
  input  logic [7:0]           wdata,
  input  logic [DW-1:0]        clr_disp,
  output logic [7:0]           rchar
);
  import tdr_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rdata;
  logic             rvalid;

  // RAM write and registered read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (mcmd.wr) begin
      mem[addr] <= wdata;
    end
    if (mcmd.rd) begin
      rdata <= mem[addr];
    end
  end

  // Valid bits: set on write, dropped per display on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (mcmd.wr) begin
        valid[addr] <= 1'b1;
      end
      if (mcmd.clr) begin
        for (int i = 0; i < DEPTH; i++) begin
          if ((i / CELLS) == int'(clr_disp)) begin
            valid[i] <= 1'b0;
          end
        end
      end
      if (mcmd.rd) begin
        rvalid <= valid[addr];
      end
    end
  end

  // Never-written or cleared cells show as spaces
  assign rchar = rvalid ? rdata : CHAR_SPACE;

endmodule

/* sv/tdr_ctrl.sv */
// Command decode and per-display write and scan cursors.
// Drives memory requests for tdr_store and the refresh tag. Uses tdr_pkg.
module tdr_ctrl #(
  parameter int DISPLAYS = 2,
  parameter int ROWS     = 2,
  parameter int COLS     = 16,
  parameter int AW       = 6,
  parameter int DW       = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  tdr_pkg::tdr_in_t       cmd,
  output tdr_pkg::tdr_mem_cmd_t  mcmd,
  output logic [AW-1:0]          addr,
  output logic [7:0]             wdata,
  output logic [DW-1:0]          clr_disp,
  output tdr_pkg::tdr_out_t      meta
);
  import tdr_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLS);

  logic [RW-1:0] scan_row  [DISPLAYS];
  logic [CW-1:0] scan_col  [DISPLAYS];
  logic [RW-1:0] write_row [DISPLAYS];
  logic [CW-1:0] write_col [DISPLAYS];

  logic [DW-1:0] di;
  logic          d_ok, pos_ok;
  logic [RW-1:0] cr, wr_next, sr_next, cur_r;
  logic [CW-1:0] cc, wc_next, sc_next, cur_c;
  logic          upd_w, upd_s;

  // Next cell, column first, wrapping to row 0 after the last row
  function automatic logic [RW+CW-1:0] step_pos(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    nr = r;
    nc = c + CW'(1);
    if (int'(c) == COLS - 1) begin
      nc = '0;
      nr = (int'(r) == ROWS - 1) ? '0 : r + RW'(1);
    end
    return {nr, nc};
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] d,
                                              input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(int'(d) * CELLS + int'(r) * COLS + int'(c));
  endfunction

  assign di     = DW'(cmd.display_id);
  assign d_ok   = int'(cmd.display_id) < DISPLAYS;
  assign pos_ok = (int'(cmd.row) < ROWS) && (int'(cmd.column) < COLS);
  assign cr     = RW'(cmd.row);
  assign cc     = CW'(cmd.column);

  // Decode one accepted transaction
  always_comb begin
    mcmd     = '0;
    cur_r    = cr;
    cur_c    = cc;
    wr_next  = '0;
    wc_next  = '0;
    sr_next  = '0;
    sc_next  = '0;
    upd_w    = 1'b0;
    upd_s    = 1'b0;
    wdata    = cmd.char_code;
    clr_disp = di;
    if (fire && d_ok) begin
      unique case (cmd.action)
        ACT_PUT: begin
          mcmd.wr = pos_ok;
        end
        ACT_BEGIN: begin
          mcmd.wr            = pos_ok;
          upd_w              = pos_ok;
          {wr_next, wc_next} = step_pos(cr, cc);
        end
        ACT_CONT: begin
          cur_r              = write_row[di];
          cur_c              = write_col[di];
          mcmd.wr            = 1'b1;
          upd_w              = 1'b1;
          {wr_next, wc_next} = step_pos(cur_r, cur_c);
        end
        ACT_CLEAR: begin
          mcmd.clr = 1'b1;
        end
        ACT_INIT: begin
          mcmd.clr = 1'b1;
          upd_s    = 1'b1;
        end
        ACT_TICK: begin
          cur_r              = scan_row[di];
          cur_c              = scan_col[di];
          mcmd.rd            = 1'b1;
          upd_s              = 1'b1;
          {sr_next, sc_next} = step_pos(cur_r, cur_c);
        end
        default: begin
          mcmd = '0;
        end
      endcase
    end
    addr = cell_addr(di, cur_r, cur_c);
  end

  // Tag for the refresh read in flight
  always_comb begin
    meta.out_display = cmd.display_id;
    meta.out_row     = 1'(cur_r);
    meta.out_column  = 4'(cur_c);
    meta.out_char    = '0;
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DISPLAYS; i++) begin
        scan_row[i]  <= '0;
        scan_col[i]  <= '0;
        write_row[i] <= '0;
        write_col[i] <= '0;
      end
    end else begin
      if (upd_w) begin
        write_row[di] <= wr_next;
        write_col[di] <= wc_next;
      end
      if (upd_s) begin
        scan_row[di] <= sr_next;
        scan_col[di] <= sc_next;
      end
    end
  end

endmodule

/* sv/tdr_checker.sv */
// Port-level checks for text_display_refresh_buffer, attached by bind.
// Uses tdr_pkg for the command codes and transaction types.
module tdr_checker #(
  parameter int DISPLAYS = tdr_pkg::DEF_DISPLAYS
) (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input tdr_pkg::tdr_in_t  cmd,
  input logic              cell_valid,
  input logic              cell_ready,
  input tdr_pkg::tdr_out_t cell_data
);
  import tdr_pkg::*;

  logic tick_fire;

  // A tick transaction that yields a cell
  assign tick_fire = cmd_valid && cmd_ready && (cmd.action == ACT_TICK) &&
                     (int'(cmd.display_id) < DISPLAYS);

  // Stalled cell holds
  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_ready |=> cell_valid && $stable(cell_data))
    else $error("cell changed while stalled");

  // Command side only backs up behind a stalled cell
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> cell_valid && !cell_ready)
    else $error("cmd_ready low without a stalled cell");

  // A tick whose read result finds room downstream then shows its cell
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    (tick_fire ##1 (!cell_valid || cell_ready)) |=> cell_valid)
    else $error("tick produced no cell");

  // A fresh cell comes only from an earlier tick that passed the read stage
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(cell_valid) |-> $past(tick_fire, 2))
    else $error("cell without a tick");

endmodule

bind text_display_refresh_buffer tdr_checker #(.DISPLAYS(DISPLAYS)) u_tdr_checker (.*);
